// ===== sv/rsels_pkg.sv =====
// Shared types and constants for the RTP sequence extension / loss statistics block.
// No dependencies; imported by rtp_sequence_extend_loss_stats.
package rsels_pkg;

    // request kinds (input tuser)
    typedef enum logic [1:0] {
        REQ_PACKET  = 2'd0,
        REQ_REPORT  = 2'd1,
        REQ_RESET   = 2'd2,
        REQ_ABANDON = 2'd3
    } t_req;

    // result kinds (output tuser)
    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_FIRST    = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_REPORT   = 3'd3,
        ST_ACK      = 3'd4
    } t_status;

    localparam int SEQ_W   = 16;
    localparam int EXT_W   = 32;
    localparam int SSRC_W  = 32;
    localparam int CNT_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int CUM_W   = 24;
    localparam int ALU_W   = 34;
    localparam int IN_DW   = 64;
    localparam int OUT_DW  = 96;
    localparam int IN_UW   = 2;
    localparam int OUT_UW  = 3;

    localparam logic [CUM_W-1:0] CUM_MAX = 24'h7fffff;
    localparam logic [CUM_W-1:0] CUM_MIN = 24'h800000;

endpackage

// ===== sv/rtp_sequence_extend_loss_stats.sv =====
// RTP receive statistics for one stream: sequence extension and loss reports.
// Depends on rsels_pkg (request/status codes, widths).
//
// Usage:
//   Input channel (s_axis_*): one request item per handshake. tuser carries the
//   request kind (packet, report, timeline reset, abandon); tdata carries the
//   sequence number, the SSRC and the abandon count.
//   Output channel (m_axis_*): exactly one result item per request. tuser holds
//   the status code, tdata the extended sequence, fraction lost, cumulative
//   loss and highest extended sequence.
//   All arithmetic runs through one shared 34-bit add/subtract unit stepped by
//   a small sequencer. A packet runs from accept to result through three
//   candidate distances, two compares and one max update; a report runs five
//   setup subtractions, a saturation compare and an 8-step restoring division;
//   reset and abandon go straight from dispatch to the result. The sequencer holds
//   one item at a time, so s_axis_tready is high only between items.
//   The result sits in an output register: the next request is accepted while
//   it waits, and the sequencer stalls at its final step only if the previous
//   result has still not been taken.
//   Synchronous active-low reset clears the statistics, the sequencer and the
//   output valid; a timeline reset request does the same to the statistics.
module rtp_sequence_extend_loss_stats (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [15:0] seq_low, [47:16] stream_ssrc, [63:48] abandon_count
    input  logic [rsels_pkg::IN_DW-1:0]   s_axis_tdata,
    // [1:0] req_type
    input  logic [rsels_pkg::IN_UW-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [31:0] extended_seq, [39:32] fraction_lost, [63:40] cumulative_lost,
    // [95:64] highest_seq
    output logic [rsels_pkg::OUT_DW-1:0]  m_axis_tdata,
    // [2:0] status
    output logic [rsels_pkg::OUT_UW-1:0]  m_axis_tuser
);
    import rsels_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_X_DIFF,
        S_X_ABS,
        S_X_CMP1,
        S_X_CMP2,
        S_X_MAX,
        S_R_EXP,
        S_R_IEXP,
        S_R_IREC,
        S_R_LOST,
        S_R_CUM,
        S_R_CMP,
        S_R_DIV,
        S_OUT
    } t_state;

    t_state             r_state;

    // stream statistics
    logic               r_started;
    logic [SSRC_W-1:0]  r_first_ssrc;
    logic [EXT_W-1:0]   r_high;
    logic [EXT_W-1:0]   r_base;
    logic [EXT_W-1:0]   r_recv;
    logic [EXT_W-1:0]   r_prev_exp;
    logic [EXT_W-1:0]   r_prev_rec;

    // latched request
    t_req               r_req;
    logic [SEQ_W-1:0]   r_seq;
    logic [SSRC_W-1:0]  r_ssrc;
    logic [CNT_W-1:0]   r_cnt;

    // working registers
    logic [ALU_W-1:0]   r_diff;
    logic [EXT_W-1:0]   r_dist [3];
    logic [1:0]         r_idx;
    logic               r_lt1;
    logic [EXT_W-1:0]   r_ext;
    t_status            r_status;
    logic [EXT_W-1:0]   r_exp;
    logic [EXT_W-1:0]   r_iexp;
    logic [EXT_W-1:0]   r_irec;
    logic [ALU_W-1:0]   r_lost;
    logic [CUM_W-1:0]   r_cum;
    logic [FRAC_W-1:0]  r_frac;
    logic [EXT_W-1:0]   r_rem;
    logic [2:0]         r_div_cnt;

    // output register
    logic               r_out_valid;
    t_status            r_out_status;
    logic [EXT_W-1:0]   r_out_ext;
    logic [FRAC_W-1:0]  r_out_frac;
    logic [CUM_W-1:0]   r_out_cum;
    logic [EXT_W-1:0]   r_out_high;

    // shared add/subtract unit
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    logic               alu_inv;
    logic [1:0]         alu_cin;
    logic [ALU_W-1:0]   alu_res;
    logic               alu_neg;

    // epoch candidates around the highest sequence
    logic [SEQ_W-1:0]   top;
    logic [EXT_W-1:0]   c_cur;
    logic [EXT_W-1:0]   c_next;
    logic [EXT_W-1:0]   c_prev;
    logic [EXT_W-1:0]   c_sel;
    logic [EXT_W-1:0]   c_pick;

    logic               in_acc;
    logic               out_free;
    logic [EXT_W-1:0]   cum32;
    logic [CUM_W-1:0]   cum_sat;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign top    = r_high[EXT_W-1:SEQ_W];
    assign c_cur  = {top, r_seq};
    assign c_next = {top + 16'd1, r_seq};
    assign c_prev = {top - 16'd1, r_seq};

    always_comb begin
        case (r_idx)
            2'd1:    c_sel = c_next;
            2'd2:    c_sel = c_prev;
            default: c_sel = c_cur;
        endcase
    end

    // closest candidate after the second compare
    assign c_pick = r_lt1 ? (alu_neg ? c_cur : c_prev) : (alu_neg ? c_next : c_prev);

    // operand selection per sequencer step
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_inv = 1'b0;
        alu_cin = 2'd0;
        case (r_state)
            S_START: begin
                alu_a = {2'b00, r_recv};
                if (r_req == REQ_ABANDON) begin
                    alu_b   = {{(ALU_W-CNT_W){1'b0}}, r_cnt};
                    alu_inv = 1'b1;
                end
                alu_cin = 2'd1;
            end
            S_X_DIFF: begin
                alu_a   = {2'b00, c_sel};
                alu_b   = {2'b00, r_high};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_X_ABS: begin
                alu_b   = r_diff;
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_X_CMP1: begin
                alu_a   = {2'b00, r_dist[0]};
                alu_b   = {2'b00, r_dist[1]};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_X_CMP2: begin
                alu_a   = {2'b00, (r_lt1 ? r_dist[0] : r_dist[1])};
                alu_b   = {2'b00, r_dist[2]};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_X_MAX: begin
                alu_a   = {2'b00, r_high};
                alu_b   = {2'b00, r_ext};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_R_EXP: begin
                // highest - base + 1
                alu_a   = {2'b00, r_high};
                alu_b   = {2'b00, r_base};
                alu_inv = 1'b1;
                alu_cin = 2'd2;
            end
            S_R_IEXP: begin
                alu_a   = {2'b00, r_exp};
                alu_b   = {2'b00, r_prev_exp};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_R_IREC: begin
                alu_a   = {2'b00, r_recv};
                alu_b   = {2'b00, r_prev_rec};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_R_LOST: begin
                // unsigned interval expected minus signed interval received
                alu_a   = {2'b00, r_iexp};
                alu_b   = {{2{r_irec[EXT_W-1]}}, r_irec};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_R_CUM: begin
                alu_a   = {2'b00, r_exp};
                alu_b   = {2'b00, r_recv};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_R_CMP: begin
                alu_a   = r_lost;
                alu_b   = {2'b00, r_iexp};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            S_R_DIV: begin
                alu_a   = {1'b0, r_rem, 1'b0};
                alu_b   = {2'b00, r_iexp};
                alu_inv = 1'b1;
                alu_cin = 2'd1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_res = alu_a + (alu_inv ? ~alu_b : alu_b) + {{(ALU_W-2){1'b0}}, alu_cin};
    assign alu_neg = alu_res[ALU_W-1];

    // cumulative loss: 32-bit wrapped difference saturated to 24 bits signed
    assign cum32 = alu_res[EXT_W-1:0];
    always_comb begin
        if (cum32[EXT_W-1] && !(&cum32[EXT_W-2:CUM_W-1])) begin
            cum_sat = CUM_MIN;
        end else if (!cum32[EXT_W-1] && (|cum32[EXT_W-2:CUM_W-1])) begin
            cum_sat = CUM_MAX;
        end else begin
            cum_sat = cum32[CUM_W-1:0];
        end
    end

    // sequencer, statistics and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_started    <= 1'b0;
            r_first_ssrc <= '0;
            r_high       <= '0;
            r_base       <= '0;
            r_recv       <= '0;
            r_prev_exp   <= '0;
            r_prev_rec   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_req   <= t_req'(s_axis_tuser);
                        r_seq   <= s_axis_tdata[15:0];
                        r_ssrc  <= s_axis_tdata[47:16];
                        r_cnt   <= s_axis_tdata[63:48];
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_ext  <= '0;
                    r_frac <= '0;
                    r_cum  <= '0;
                    r_idx  <= 2'd0;
                    case (r_req)
                        REQ_PACKET: begin
                            r_recv <= alu_res[EXT_W-1:0];
                            if (!r_started) begin
                                r_started    <= 1'b1;
                                r_first_ssrc <= r_ssrc;
                                r_high       <= {16'd0, r_seq};
                                r_base       <= {16'd0, r_seq};
                                r_ext        <= {16'd0, r_seq};
                                r_status     <= ST_FIRST;
                                r_state      <= S_OUT;
                            end else if (r_ssrc != r_first_ssrc) begin
                                r_status <= ST_MISMATCH;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_X_DIFF;
                            end
                        end
                        REQ_REPORT: begin
                            r_state <= S_R_EXP;
                        end
                        REQ_RESET: begin
                            r_started    <= 1'b0;
                            r_first_ssrc <= '0;
                            r_high       <= '0;
                            r_base       <= '0;
                            r_recv       <= '0;
                            r_prev_exp   <= '0;
                            r_prev_rec   <= '0;
                            r_status     <= ST_ACK;
                            r_state      <= S_OUT;
                        end
                        default: begin
                            r_recv   <= alu_res[EXT_W-1:0];
                            r_status <= ST_ACK;
                            r_state  <= S_OUT;
                        end
                    endcase
                end
                // candidate distance: signed difference, then magnitude
                S_X_DIFF: begin
                    r_diff  <= alu_res;
                    r_state <= S_X_ABS;
                end
                S_X_ABS: begin
                    r_dist[r_idx] <= r_diff[ALU_W-1] ? alu_res[EXT_W-1:0] : r_diff[EXT_W-1:0];
                    if (r_idx == 2'd2) begin
                        r_state <= S_X_CMP1;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_X_DIFF;
                    end
                end
                S_X_CMP1: begin
                    r_lt1   <= alu_neg;
                    r_state <= S_X_CMP2;
                end
                S_X_CMP2: begin
                    r_ext   <= c_pick;
                    r_state <= S_X_MAX;
                end
                S_X_MAX: begin
                    if (alu_neg) begin
                        r_high <= r_ext;
                    end
                    r_status <= ST_ACCEPTED;
                    r_state  <= S_OUT;
                end
                // report setup
                S_R_EXP: begin
                    r_exp   <= alu_res[EXT_W-1:0];
                    r_state <= S_R_IEXP;
                end
                S_R_IEXP: begin
                    r_iexp  <= alu_res[EXT_W-1:0];
                    r_state <= S_R_IREC;
                end
                S_R_IREC: begin
                    r_irec  <= alu_res[EXT_W-1:0];
                    r_state <= S_R_LOST;
                end
                S_R_LOST: begin
                    r_lost  <= alu_res;
                    r_state <= S_R_CUM;
                end
                S_R_CUM: begin
                    r_cum      <= cum_sat;
                    r_prev_exp <= r_exp;
                    r_prev_rec <= r_recv;
                    r_status   <= ST_REPORT;
                    r_state    <= S_R_CMP;
                end
                // no loss, full saturation, or divide
                S_R_CMP: begin
                    if (r_lost[ALU_W-1] || r_lost == '0 || r_iexp == '0) begin
                        r_state <= S_OUT;
                    end else if (!alu_neg) begin
                        r_frac  <= '1;
                        r_state <= S_OUT;
                    end else begin
                        r_rem     <= r_lost[EXT_W-1:0];
                        r_div_cnt <= 3'd0;
                        r_state   <= S_R_DIV;
                    end
                end
                // restoring division, one quotient bit a step
                S_R_DIV: begin
                    r_rem     <= alu_neg ? {r_rem[EXT_W-2:0], 1'b0} : alu_res[EXT_W-1:0];
                    r_frac    <= {r_frac[FRAC_W-2:0], !alu_neg};
                    r_div_cnt <= r_div_cnt + 3'd1;
                    if (r_div_cnt == 3'd7) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_ext    <= r_ext;
                        r_out_frac   <= r_frac;
                        r_out_cum    <= r_cum;
                        r_out_high   <= r_high;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_high, r_out_cum, r_out_frac, r_out_ext};
    assign m_axis_tuser  = r_out_status;

    // an accepted item always starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_START))
        else $error("accepted item did not start the sequencer");

    // division only runs with a nonzero divisor and a remainder below it
    a_div_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_R_DIV) |-> (r_iexp != '0 && r_rem < r_iexp))
        else $error("division remainder out of range");

    // highest sequence changes only at dispatch or the max step
    a_high_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_START && r_state != S_X_MAX) |=> $stable(r_high))
        else $error("highest sequence changed outside its update steps");

    // a result is loaded only when the output register is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !m_axis_tready) |=> (r_state == S_OUT))
        else $error("result overwritten while output stalled");

endmodule
